// File: rtl/s5hp_pkg.sv
// ----------------------------------------------------------------------------
// s5hp_pkg
// Types and constants shared by the SOCKS5 handshake parser.
// ----------------------------------------------------------------------------
package s5hp_pkg;

    typedef enum logic [3:0] {
        PH_G_VER   = 4'd0,
        PH_G_NMETH = 4'd1,
        PH_G_METH  = 4'd2,
        PH_R_VER   = 4'd3,
        PH_R_CMD   = 4'd4,
        PH_R_RSV   = 4'd5,
        PH_R_ATYP  = 4'd6,
        PH_A_LEN   = 4'd7,
        PH_A_BYTES = 4'd8,
        PH_P_HI    = 4'd9,
        PH_P_LO    = 4'd10,
        PH_DONE    = 4'd11
    } phase_t;

    typedef enum logic [3:0] {
        ST_WAIT     = 4'd0,
        ST_GREETED  = 4'd1,
        ST_ADDR     = 4'd2,
        ST_COMPLETE = 4'd3,
        ST_BAD_VER  = 4'd4,
        ST_NO_METH  = 4'd5,
        ST_BAD_CMD  = 4'd6,
        ST_BAD_ATYP = 4'd7,
        ST_BAD_LEN  = 4'd8,
        ST_IGNORED  = 4'd9
    } status_t;

    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] CMD_CONNECT    = 8'h01;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] ATYP_IPV6      = 8'h04;

    localparam logic [1:0] AK_IPV4        = 2'd0;
    localparam logic [1:0] AK_DOMAIN      = 2'd1;
    localparam logic [1:0] AK_IPV6        = 2'd2;

    localparam logic [7:0] IPV4_LEN       = 8'd4;
    localparam logic [7:0] IPV6_LEN       = 8'd16;
    localparam logic [7:0] MAX_DOMAIN_RST = 8'd255;

    localparam int BAD_VER_BIT = 0;
    localparam int BAD_CMD_BIT = 1;

    typedef struct packed {
        status_t     status;
        logic [1:0]  addr_type;
        logic [7:0]  addr_byte;
        logic [7:0]  addr_index;
        logic [15:0] port;
    } res_t;

endpackage

// File: rtl/s5hp_in_if.sv
// ----------------------------------------------------------------------------
// s5hp_in_if
// Client item channel: session start flag and received byte.
// ----------------------------------------------------------------------------
interface s5hp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// File: rtl/s5hp_out_if.sv
// ----------------------------------------------------------------------------
// s5hp_out_if
// Result item channel: parse status, address bytes and port.
// ----------------------------------------------------------------------------
interface s5hp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [1:0]  addr_type;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [15:0] port;

    modport source (output valid, output status, output addr_type, output addr_byte,
                    output addr_index, output port, input ready);
    modport sink   (input valid, input status, input addr_type, input addr_byte,
                    input addr_index, input port, output ready);
endinterface

// File: rtl/socks5_handshake_parser_unit.sv
// An accepted item moves from the input register to the result register, which offers it.
// Throughput: one item per cycle while results are taken; the input and result registers each hold one item.
// Input ready drops only while both registers are full and the result is not taken.
// Reset: parser back to the greeting version byte, max_domain_len to 255,
// both registers empty.
// ----------------------------------------------------------------------------
// socks5_handshake_parser_unit
// SOCKS5 server-side opening exchange parser, one client byte per item.
// ----------------------------------------------------------------------------
module socks5_handshake_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    s5hp_in_if.sink     rx,
    s5hp_out_if.source  res
);

    logic           item_valid;
    logic           item_kind;
    logic [7:0]     item_byte;
    logic           advance;
    logic [7:0]     max_len_reg;
    logic           res_valid_reg;
    logic           res_valid_next;
    s5hp_pkg::res_t step_res;
    s5hp_pkg::res_t res_reg;

    assign advance        = item_valid && (!res_valid_reg || res.ready);
    assign res_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    s5hp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .item_valid (item_valid),
        .item_kind  (item_kind),
        .item_byte  (item_byte)
    );

    s5hp_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .kind           (item_kind),
        .rx_byte        (item_byte),
        .max_domain_len (max_len_reg),
        .result         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= s5hp_pkg::MAX_DOMAIN_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.status     = res_reg.status;
    assign res.addr_type  = res_reg.addr_type;
    assign res.addr_byte  = res_reg.addr_byte;
    assign res.addr_index = res_reg.addr_index;
    assign res.port       = res_reg.port;

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (item_valid && res_valid_reg && !res.ready))
        else $error("input stalled with room in the pipeline");

    a_item_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> item_valid)
        else $error("queued item lost while result stalled");

    a_addr_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status != s5hp_pkg::ST_ADDR))
            |-> ((res_reg.addr_byte == 8'd0) && (res_reg.addr_index == 8'd0)))
        else $error("address fields set outside an address byte");

    a_port_only_on_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status != s5hp_pkg::ST_COMPLETE))
            |-> (res_reg.port == 16'd0))
        else $error("port set outside completion");

endmodule

// File: rtl/s5hp_in_stage.sv
// ----------------------------------------------------------------------------
// s5hp_in_stage
// Input register for client items; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module s5hp_in_stage (
    input  logic    clk,
    input  logic    rst_n,
    s5hp_in_if.sink rx,
    input  logic    advance,
    output logic    item_valid,
    output logic    item_kind,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       take;

    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= rx.kind;
            byte_reg <= rx.rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_kind  = kind_reg;
    assign item_byte  = byte_reg;

endmodule

// File: rtl/s5hp_parse.sv
// ----------------------------------------------------------------------------
// s5hp_parse
// Parser state and single-pass step logic for one item.
// ----------------------------------------------------------------------------
module s5hp_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            kind,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      max_domain_len,
    output s5hp_pkg::res_t  result
);

    s5hp_pkg::phase_t phase_reg;
    s5hp_pkg::phase_t phase_next;
    logic [7:0]       remaining_reg;
    logic [7:0]       remaining_next;
    logic [7:0]       position_reg;
    logic [7:0]       position_next;
    logic [1:0]       kind_reg;
    logic [1:0]       kind_next;
    logic [1:0]       bad_reg;
    logic [1:0]       bad_next;
    logic [7:0]       port_hi_reg;
    logic [7:0]       port_hi_next;
    logic [7:0]       rem_dec;

    assign rem_dec = remaining_reg - 8'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        remaining_next      = remaining_reg;
        position_next       = position_reg;
        kind_next           = kind_reg;
        bad_next            = bad_reg;
        port_hi_next        = port_hi_reg;
        result.status       = s5hp_pkg::ST_WAIT;
        result.addr_byte    = 8'd0;
        result.addr_index   = 8'd0;
        result.port         = 16'd0;

        if (kind)
        begin
            phase_next     = s5hp_pkg::PH_G_VER;
            remaining_next = 8'd0;
            position_next  = 8'd0;
            kind_next      = s5hp_pkg::AK_IPV4;
            bad_next       = 2'd0;
            port_hi_next   = 8'd0;
        end
        else
        begin
            case (phase_reg)
                s5hp_pkg::PH_G_VER:
                begin
                    if (rx_byte != s5hp_pkg::SOCKS_VER)
                    begin
                        result.status = s5hp_pkg::ST_BAD_VER;
                        phase_next    = s5hp_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = s5hp_pkg::PH_G_NMETH;
                    end
                end
                s5hp_pkg::PH_G_NMETH:
                begin
                    if (rx_byte == 8'd0)
                    begin
                        result.status = s5hp_pkg::ST_NO_METH;
                        phase_next    = s5hp_pkg::PH_DONE;
                    end
                    else
                    begin
                        remaining_next = rx_byte;
                        phase_next     = s5hp_pkg::PH_G_METH;
                    end
                end
                s5hp_pkg::PH_G_METH:
                begin
                    remaining_next = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        result.status = s5hp_pkg::ST_GREETED;
                        phase_next    = s5hp_pkg::PH_R_VER;
                    end
                end
                s5hp_pkg::PH_R_VER:
                begin
                    bad_next = 2'd0;
                    bad_next[s5hp_pkg::BAD_VER_BIT] = (rx_byte != s5hp_pkg::SOCKS_VER);
                    phase_next = s5hp_pkg::PH_R_CMD;
                end
                s5hp_pkg::PH_R_CMD:
                begin
                    if (rx_byte != s5hp_pkg::CMD_CONNECT)
                    begin
                        bad_next[s5hp_pkg::BAD_CMD_BIT] = 1'b1;
                    end
                    phase_next = s5hp_pkg::PH_R_RSV;
                end
                s5hp_pkg::PH_R_RSV:
                begin
                    phase_next = s5hp_pkg::PH_R_ATYP;
                end
                s5hp_pkg::PH_R_ATYP:
                begin
                    if (bad_reg[s5hp_pkg::BAD_VER_BIT])
                    begin
                        result.status = s5hp_pkg::ST_BAD_VER;
                        phase_next    = s5hp_pkg::PH_DONE;
                    end
                    else if (bad_reg[s5hp_pkg::BAD_CMD_BIT])
                    begin
                        result.status = s5hp_pkg::ST_BAD_CMD;
                        phase_next    = s5hp_pkg::PH_DONE;
                    end
                    else if (rx_byte == s5hp_pkg::ATYP_IPV4)
                    begin
                        kind_next      = s5hp_pkg::AK_IPV4;
                        remaining_next = s5hp_pkg::IPV4_LEN;
                        position_next  = 8'd0;
                        phase_next     = s5hp_pkg::PH_A_BYTES;
                    end
                    else if (rx_byte == s5hp_pkg::ATYP_DOMAIN)
                    begin
                        kind_next  = s5hp_pkg::AK_DOMAIN;
                        phase_next = s5hp_pkg::PH_A_LEN;
                    end
                    else if (rx_byte == s5hp_pkg::ATYP_IPV6)
                    begin
                        kind_next      = s5hp_pkg::AK_IPV6;
                        remaining_next = s5hp_pkg::IPV6_LEN;
                        position_next  = 8'd0;
                        phase_next     = s5hp_pkg::PH_A_BYTES;
                    end
                    else
                    begin
                        result.status = s5hp_pkg::ST_BAD_ATYP;
                        phase_next    = s5hp_pkg::PH_DONE;
                    end
                end
                s5hp_pkg::PH_A_LEN:
                begin
                    if ((rx_byte == 8'd0) || (rx_byte > max_domain_len))
                    begin
                        result.status = s5hp_pkg::ST_BAD_LEN;
                        phase_next    = s5hp_pkg::PH_DONE;
                    end
                    else
                    begin
                        remaining_next = rx_byte;
                        position_next  = 8'd0;
                        phase_next     = s5hp_pkg::PH_A_BYTES;
                    end
                end
                s5hp_pkg::PH_A_BYTES:
                begin
                    result.status     = s5hp_pkg::ST_ADDR;
                    result.addr_byte  = rx_byte;
                    result.addr_index = position_reg;
                    position_next     = position_reg + 8'd1;
                    remaining_next    = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        phase_next = s5hp_pkg::PH_P_HI;
                    end
                end
                s5hp_pkg::PH_P_HI:
                begin
                    port_hi_next = rx_byte;
                    phase_next   = s5hp_pkg::PH_P_LO;
                end
                s5hp_pkg::PH_P_LO:
                begin
                    result.status = s5hp_pkg::ST_COMPLETE;
                    result.port   = {port_hi_reg, rx_byte};
                    phase_next    = s5hp_pkg::PH_DONE;
                end
                default:
                begin
                    result.status = s5hp_pkg::ST_IGNORED;
                    phase_next    = s5hp_pkg::PH_DONE;
                end
            endcase
        end

        result.addr_type = kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= s5hp_pkg::PH_G_VER;
            remaining_reg <= 8'd0;
            position_reg  <= 8'd0;
            kind_reg      <= s5hp_pkg::AK_IPV4;
            bad_reg       <= 2'd0;
            port_hi_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            kind_reg      <= kind_next;
            bad_reg       <= bad_next;
            port_hi_reg   <= port_hi_next;
        end
    end

endmodule

// File: bench/socks5_handshake_parser_unit_test.sv
// ----------------------------------------------------------------------------
// socks5_handshake_parser_unit_test
// Self-checking bench for the SOCKS5 handshake parser. A directed table covers
// the edge bytes, the version, no-method and domain length fault codes and session
// restarts. Random greeting and request sessions follow, some cut short and some pure
// noise, under six domain length limits and several idle patterns. Each result is
// checked against its table row or an in-bench parser model.
// ----------------------------------------------------------------------------
module socks5_handshake_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 290;
    localparam int STALL_CYCLES = 80;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        logic       kind;
        logic [7:0] b;
    } client_item_t;

    typedef struct packed {
        logic           kind;
        logic [7:0]     b;
        logic           typed;
        s5hp_pkg::res_t res;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    // typed expectation travels with the item it belongs to
    logic           exp_typed;
    s5hp_pkg::res_t exp_fixed;

    s5hp_in_if  rx_ch ();
    s5hp_out_if res_ch ();

    socks5_handshake_parser_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx_ch.sink),
        .res         (res_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser model state
    s5hp_pkg::phase_t ph        = s5hp_pkg::PH_G_VER;
    logic [7:0]       left_cnt  = '0;
    logic [7:0]       addr_pos  = '0;
    logic [1:0]       akind     = s5hp_pkg::AK_IPV4;
    logic [1:0]       req_fault = '0;
    logic [7:0]       port_hi   = '0;
    logic [7:0]       dom_max   = s5hp_pkg::MAX_DOMAIN_RST;

    s5hp_pkg::res_t pending_q[$];
    client_item_t   session_q[$];
    dir_row_t       dir_tab[DIR_ROWS];

    int fail_cnt     = 0;
    int items_cnt    = 0;
    int results_cnt  = 0;
    int complete_cnt = 0;
    int cycle_cnt    = 0;
    int tx_idle      = 0;
    int rx_idle      = 0;
    int stall_left   = 0;
    bit stall_req    = 1'b0;

    function automatic void clear_parser_state();
        ph        = s5hp_pkg::PH_G_VER;
        left_cnt  = '0;
        addr_pos  = '0;
        akind     = s5hp_pkg::AK_IPV4;
        req_fault = '0;
        port_hi   = '0;
    endfunction

    function automatic s5hp_pkg::res_t parse_item(input logic kind, input logic [7:0] b);
        s5hp_pkg::res_t r;
        r = '0;
        r.status = s5hp_pkg::ST_WAIT;
        if (kind)
        begin
            clear_parser_state();
        end
        else
        begin
            case (ph)
                s5hp_pkg::PH_G_VER:
                begin
                    if (b != s5hp_pkg::SOCKS_VER)
                    begin
                        r.status = s5hp_pkg::ST_BAD_VER;
                        ph = s5hp_pkg::PH_DONE;
                    end
                    else
                        ph = s5hp_pkg::PH_G_NMETH;
                end
                s5hp_pkg::PH_G_NMETH:
                begin
                    if (b == 8'h00)
                    begin
                        r.status = s5hp_pkg::ST_NO_METH;
                        ph = s5hp_pkg::PH_DONE;
                    end
                    else
                    begin
                        left_cnt = b;
                        ph = s5hp_pkg::PH_G_METH;
                    end
                end
                s5hp_pkg::PH_G_METH:
                begin
                    left_cnt = left_cnt - 8'd1;
                    if (left_cnt == 8'h00)
                    begin
                        r.status = s5hp_pkg::ST_GREETED;
                        ph = s5hp_pkg::PH_R_VER;
                    end
                end
                s5hp_pkg::PH_R_VER:
                begin
                    req_fault = '0;
                    req_fault[s5hp_pkg::BAD_VER_BIT] = (b != s5hp_pkg::SOCKS_VER);
                    ph = s5hp_pkg::PH_R_CMD;
                end
                s5hp_pkg::PH_R_CMD:
                begin
                    if (b != s5hp_pkg::CMD_CONNECT)
                        req_fault[s5hp_pkg::BAD_CMD_BIT] = 1'b1;
                    ph = s5hp_pkg::PH_R_RSV;
                end
                s5hp_pkg::PH_R_RSV:
                    ph = s5hp_pkg::PH_R_ATYP;
                s5hp_pkg::PH_R_ATYP:
                begin
                    if (req_fault[s5hp_pkg::BAD_VER_BIT])
                    begin
                        r.status = s5hp_pkg::ST_BAD_VER;
                        ph = s5hp_pkg::PH_DONE;
                    end
                    else if (req_fault[s5hp_pkg::BAD_CMD_BIT])
                    begin
                        r.status = s5hp_pkg::ST_BAD_CMD;
                        ph = s5hp_pkg::PH_DONE;
                    end
                    else if (b == s5hp_pkg::ATYP_IPV4)
                    begin
                        akind = s5hp_pkg::AK_IPV4;
                        left_cnt = s5hp_pkg::IPV4_LEN;
                        addr_pos = '0;
                        ph = s5hp_pkg::PH_A_BYTES;
                    end
                    else if (b == s5hp_pkg::ATYP_DOMAIN)
                    begin
                        akind = s5hp_pkg::AK_DOMAIN;
                        ph = s5hp_pkg::PH_A_LEN;
                    end
                    else if (b == s5hp_pkg::ATYP_IPV6)
                    begin
                        akind = s5hp_pkg::AK_IPV6;
                        left_cnt = s5hp_pkg::IPV6_LEN;
                        addr_pos = '0;
                        ph = s5hp_pkg::PH_A_BYTES;
                    end
                    else
                    begin
                        r.status = s5hp_pkg::ST_BAD_ATYP;
                        ph = s5hp_pkg::PH_DONE;
                    end
                end
                s5hp_pkg::PH_A_LEN:
                begin
                    if (b == 8'h00 || b > dom_max)
                    begin
                        r.status = s5hp_pkg::ST_BAD_LEN;
                        ph = s5hp_pkg::PH_DONE;
                    end
                    else
                    begin
                        left_cnt = b;
                        addr_pos = '0;
                        ph = s5hp_pkg::PH_A_BYTES;
                    end
                end
                s5hp_pkg::PH_A_BYTES:
                begin
                    r.status = s5hp_pkg::ST_ADDR;
                    r.addr_byte = b;
                    r.addr_index = addr_pos;
                    addr_pos = addr_pos + 8'd1;
                    left_cnt = left_cnt - 8'd1;
                    if (left_cnt == 8'h00)
                        ph = s5hp_pkg::PH_P_HI;
                end
                s5hp_pkg::PH_P_HI:
                begin
                    port_hi = b;
                    ph = s5hp_pkg::PH_P_LO;
                end
                s5hp_pkg::PH_P_LO:
                begin
                    r.status = s5hp_pkg::ST_COMPLETE;
                    r.port = {port_hi, b};
                    ph = s5hp_pkg::PH_DONE;
                end
                default:
                begin
                    r.status = s5hp_pkg::ST_IGNORED;
                    ph = s5hp_pkg::PH_DONE;
                end
            endcase
        end
        r.addr_type = akind;
        return r;
    endfunction

    function automatic dir_row_t row(input logic kind, input logic [7:0] b,
                                     input logic typed = 1'b0,
                                     input s5hp_pkg::status_t st = s5hp_pkg::ST_WAIT,
                                     input logic [1:0] ak = s5hp_pkg::AK_IPV4,
                                     input logic [15:0] prt = 16'h0000);
        dir_row_t d;
        d.kind = kind;
        d.b = b;
        d.typed = typed;
        d.res = '{status: st, addr_type: ak, addr_byte: 8'h00, addr_index: 8'h00,
                  port: prt};
        return d;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        s5hp_pkg::res_t want;
        s5hp_pkg::res_t guess;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual status %0d",
                             $time, res_ch.status);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    check_field("status", 16'(want.status), 16'(res_ch.status));
                    check_field("addr_type", 16'(want.addr_type), 16'(res_ch.addr_type));
                    check_field("addr_byte", 16'(want.addr_byte), 16'(res_ch.addr_byte));
                    check_field("addr_index", 16'(want.addr_index), 16'(res_ch.addr_index));
                    check_field("port", want.port, res_ch.port);
                    results_cnt++;
                    if (want.status == s5hp_pkg::ST_COMPLETE)
                        complete_cnt++;
                end
            end
            if (rx_ch.valid && rx_ch.ready)
            begin
                guess = parse_item(rx_ch.kind, rx_ch.rx_byte);
                pending_q.push_back(exp_typed ? exp_fixed : guess);
                items_cnt++;
            end
        end
    end

    initial
    begin : result_sink
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic kind, input logic [7:0] b, input logic typed,
                             input s5hp_pkg::res_t fixed);
        if ($urandom_range(99) < tx_idle)
        begin
            rx_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.kind    <= kind;
        rx_ch.rx_byte <= b;
        exp_typed     <= typed;
        exp_fixed     <= fixed;
        do
            @(posedge clk);
        while (!rx_ch.ready);
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        dom_max = v;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        session_q.push_back('{1'b0, b});
    endfunction

    task automatic make_session();
        int          n;
        int          pick;
        logic [7:0]  atyp;
        logic [7:0]  len;
        session_q.delete();
        if ($urandom_range(99) < 8)
        begin
            n = $urandom_range(1, 8);
            repeat (n) session_q.push_back('{($urandom_range(99) < 10), 8'($urandom)});
            return;
        end
        session_q.push_back('{1'b1, 8'($urandom)});
        add_byte(($urandom_range(99) < 95) ? s5hp_pkg::SOCKS_VER : 8'($urandom));
        pick = $urandom_range(99);
        n = (pick < 3) ? 0 : (pick < 5) ? 255 : $urandom_range(1, 4);
        add_byte(8'(n));
        repeat (n) add_byte(8'($urandom));
        add_byte(($urandom_range(99) < 92) ? s5hp_pkg::SOCKS_VER : 8'($urandom));
        add_byte(($urandom_range(99) < 92) ? s5hp_pkg::CMD_CONNECT : 8'($urandom));
        add_byte(8'($urandom));
        pick = $urandom_range(99);
        atyp = (pick < 30) ? s5hp_pkg::ATYP_IPV4 : (pick < 60) ? s5hp_pkg::ATYP_DOMAIN :
               (pick < 88) ? s5hp_pkg::ATYP_IPV6 : 8'($urandom);
        add_byte(atyp);
        if (atyp == s5hp_pkg::ATYP_IPV4)
            repeat (s5hp_pkg::IPV4_LEN) add_byte(8'($urandom));
        else if (atyp == s5hp_pkg::ATYP_IPV6)
            repeat (s5hp_pkg::IPV6_LEN) add_byte(8'($urandom));
        else if (atyp == s5hp_pkg::ATYP_DOMAIN)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                len = 8'h00;
            else if (pick < 10)
                len = (dom_max == 8'hFF) ? 8'($urandom) : dom_max + 8'd1;
            else if (pick < 14)
                len = dom_max;
            else
                len = 8'($urandom_range(1, (dom_max < 16) ? dom_max : 16));
            add_byte(len);
            if (len != 8'h00 && len <= dom_max)
                repeat (len) add_byte(8'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            add_byte(8'h00);
            add_byte(8'h00);
        end
        else if (pick < 20)
        begin
            add_byte(8'hFF);
            add_byte(8'hFF);
        end
        else
        begin
            add_byte(8'($urandom));
            add_byte(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        if ($urandom_range(99) < 10)
        begin
            n = $urandom_range(1, session_q.size() - 1);
            while (session_q.size() > n)
                void'(session_q.pop_back());
        end
    endtask

    initial
    begin : stimulus
        int unsigned lim_plan[6];
        int          phase_items;
        bit          paused;
        bit          stalled;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.kind    = 1'b0;
        rx_ch.rx_byte = '0;
        exp_typed     = 1'b0;
        exp_fixed     = '0;
        // zero marks a random limit
        lim_plan = '{1, 255, 0, 1, 0, 255};
        paused = 1'b0;
        stalled = 1'b0;

        dir_tab = '{
            row(1'b0, 8'h05, 1'b1, s5hp_pkg::ST_WAIT),
            row(1'b0, 8'h01, 1'b1, s5hp_pkg::ST_WAIT),
            row(1'b0, 8'h80, 1'b1, s5hp_pkg::ST_GREETED),
            row(1'b0, 8'h05),
            row(1'b0, 8'h01),
            row(1'b0, 8'h00),
            row(1'b0, s5hp_pkg::ATYP_DOMAIN, 1'b1, s5hp_pkg::ST_WAIT, s5hp_pkg::AK_DOMAIN),
            row(1'b0, 8'h00, 1'b1, s5hp_pkg::ST_BAD_LEN, s5hp_pkg::AK_DOMAIN),
            row(1'b0, 8'h01, 1'b1, s5hp_pkg::ST_IGNORED, s5hp_pkg::AK_DOMAIN),
            row(1'b1, 8'hFF, 1'b1, s5hp_pkg::ST_WAIT),
            row(1'b0, 8'h00, 1'b1, s5hp_pkg::ST_BAD_VER),
            row(1'b1, 8'h00, 1'b1, s5hp_pkg::ST_WAIT),
            row(1'b0, 8'h05),
            row(1'b0, 8'h00, 1'b1, s5hp_pkg::ST_NO_METH),
            row(1'b1, 8'h00, 1'b1, s5hp_pkg::ST_WAIT),
            row(1'b0, 8'h05),
            row(1'b0, 8'h01),
            row(1'b0, 8'hFF),
            row(1'b0, 8'hFF),
            row(1'b0, 8'hFF),
            row(1'b0, 8'h00),
            row(1'b0, s5hp_pkg::ATYP_IPV4, 1'b1, s5hp_pkg::ST_BAD_VER),
            row(1'b1, 8'h00, 1'b1, s5hp_pkg::ST_WAIT)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].kind, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].res);

        for (int p = 0; p < 6; p++)
        begin
            write_limit((lim_plan[p] == 0) ? 8'($urandom_range(2, 254)) : 8'(lim_plan[p]));
            tx_idle = (p < 2) ? 22 : (p < 4) ? 75 : 0;
            rx_idle = (p < 2) ? 75 : (p < 4) ? 22 : 0;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                make_session();
                foreach (session_q[i])
                    send_item(session_q[i].kind, session_q[i].b, 1'b0, '0);
                phase_items += session_q.size();
                if (p == 2 && !paused && phase_items >= 150)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                if (p == 4 && !stalled && phase_items >= 100)
                begin
                    stall_req = 1'b1;
                    stalled = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("checked %0d results from %0d client items, %0d requests completed",
                 results_cnt, items_cnt, complete_cnt);
        $display("six domain limits incl. 1 and 255, idling on both sides, one long stall");
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
